[hw/rtl/frts_pkg.sv]
// Shared types, codes and name tables for the feed root tag sniffer.
`default_nettype none

package frts_pkg;

    localparam int NUM_CAND = 5;

    localparam logic [2:0] CAND_RSS     = 3'd0;
    localparam logic [2:0] CAND_FEED    = 3'd1;
    localparam logic [2:0] CAND_RDF     = 3'd2;
    localparam logic [2:0] CAND_XML     = 3'd3;
    localparam logic [2:0] CAND_COMMENT = 3'd4;

    localparam logic [1:0] KIND_UNKNOWN = 2'd0;
    localparam logic [1:0] KIND_RSS2    = 2'd1;
    localparam logic [1:0] KIND_ATOM    = 2'd2;
    localparam logic [1:0] KIND_RSS1    = 2'd3;

    localparam logic [1:0] CAUSE_RECOGNISED = 2'd0;
    localparam logic [1:0] CAUSE_MISMATCH   = 2'd1;
    localparam logic [1:0] CAUSE_ENDED      = 2'd2;

    typedef enum logic [4:0] {
        PH_SEEK    = 5'b00001,
        PH_NAME    = 5'b00010,
        PH_DELIM   = 5'b00100,
        PH_DECL    = 5'b01000,
        PH_COMMENT = 5'b10000
    } phase_t;

    typedef struct packed {
        phase_t               phase;
        logic [NUM_CAND-1:0]  name_match_mask;
        logic [2:0]           name_position;
        logic [1:0]           closer_progress;
        logic                 decided;
    } scan_state_t;

    typedef struct packed {
        logic       emit;
        logic [1:0] feed_kind;
        logic [1:0] cause;
    } scan_result_t;

    localparam scan_state_t SCAN_RESET = '{
        phase:           PH_SEEK,
        name_match_mask: {NUM_CAND{1'b1}},
        name_position:   3'd0,
        closer_progress: 2'd0,
        decided:         1'b0
    };

    function automatic logic [3:0] cand_len(input logic [2:0] cand);
        case (cand)
            CAND_RSS:     cand_len = 4'd3;
            CAND_FEED:    cand_len = 4'd4;
            CAND_RDF:     cand_len = 4'd7;
            CAND_XML:     cand_len = 4'd4;
            CAND_COMMENT: cand_len = 4'd3;
            default:      cand_len = 4'd0;
        endcase
    endfunction

    // Names are stored in lower case; the input byte is folded before compare.
    function automatic logic [7:0] cand_char(input logic [2:0] cand, input logic [2:0] pos);
        logic [55:0] text;
        case (cand)
            CAND_RSS:     text = {"rss", 32'h0};
            CAND_FEED:    text = {"feed", 24'h0};
            CAND_RDF:     text = "rdf:rdf";
            CAND_XML:     text = {"?xml", 24'h0};
            CAND_COMMENT: text = {"!--", 32'h0};
            default:      text = 56'h0;
        endcase
        cand_char = text[8'(55 - 8 * int'(pos)) -: 8];
    endfunction

endpackage

`default_nettype wire

[hw/rtl/frts_step.sv]
// Next-state and result logic for one document byte.
`default_nettype none

module frts_step (
    input  frts_pkg::scan_state_t  cur,
    input  logic [7:0]             data_byte,
    input  logic                   end_of_doc,
    output frts_pkg::scan_state_t  nxt,
    output frts_pkg::scan_result_t res
);
    import frts_pkg::*;

    logic [7:0]          folded;
    logic                is_ws;
    logic [NUM_CAND-1:0] nm;
    logic                done_valid;
    logic [2:0]          done_idx;
    logic [3:0]          pos_plus;
    logic [1:0]          delim_kind;
    scan_state_t         st;
    scan_result_t        rs;

    always_comb
    begin
        folded = (data_byte >= 8'h41 && data_byte <= 8'h5A) ? data_byte + 8'd32 : data_byte;
        is_ws = (data_byte == 8'h20) || (data_byte >= 8'h09 && data_byte <= 8'h0D);
        pos_plus = {1'b0, cur.name_position} + 4'd1;
        nm = '0;
        done_valid = 1'b0;
        done_idx = 3'd0;
        for (int i = 0; i < NUM_CAND; i++)
        begin
            if (cur.name_match_mask[i] && ({1'b0, cur.name_position} < cand_len(3'(i)))
                && cand_char(3'(i), cur.name_position) == folded)
            begin
                nm[i] = 1'b1;
            end
        end
        for (int i = 0; i < NUM_CAND; i++)
        begin
            if (nm[i] && cand_len(3'(i)) == pos_plus)
            begin
                done_valid = 1'b1;
                done_idx = 3'(i);
            end
        end
        if (cur.name_match_mask[CAND_RSS])
            delim_kind = KIND_RSS2;
        else if (cur.name_match_mask[CAND_FEED])
            delim_kind = KIND_ATOM;
        else if (cur.name_match_mask[CAND_RDF])
            delim_kind = KIND_RSS1;
        else
            delim_kind = KIND_UNKNOWN;

        st = cur;
        rs = '{emit: 1'b0, feed_kind: KIND_UNKNOWN, cause: CAUSE_RECOGNISED};

        if (!cur.decided)
        begin
            case (cur.phase)
                PH_NAME:
                begin
                    st.name_match_mask = nm;
                    if (nm == '0)
                    begin
                        rs = '{emit: 1'b1, feed_kind: KIND_UNKNOWN, cause: CAUSE_MISMATCH};
                        st.decided = 1'b1;
                    end
                    else if (!done_valid)
                    begin
                        st.name_position = pos_plus[2:0];
                    end
                    else if (done_idx < CAND_XML)
                    begin
                        st.name_match_mask = NUM_CAND'(1) << done_idx;
                        st.phase = PH_DELIM;
                    end
                    else
                    begin
                        st.phase = (done_idx == CAND_XML) ? PH_DECL : PH_COMMENT;
                        st.closer_progress = 2'd0;
                    end
                end
                PH_DELIM:
                begin
                    if (is_ws && delim_kind != KIND_UNKNOWN)
                        rs = '{emit: 1'b1, feed_kind: delim_kind, cause: CAUSE_RECOGNISED};
                    else
                        rs = '{emit: 1'b1, feed_kind: KIND_UNKNOWN, cause: CAUSE_MISMATCH};
                    st.decided = 1'b1;
                end
                PH_DECL:
                begin
                    if (cur.closer_progress == 2'd1 && data_byte == 8'h3E)
                    begin
                        st.phase = PH_SEEK;
                        st.closer_progress = 2'd0;
                    end
                    else
                    begin
                        st.closer_progress = (data_byte == 8'h3F) ? 2'd1 : 2'd0;
                    end
                end
                PH_COMMENT:
                begin
                    if (data_byte == 8'h2D)
                    begin
                        if (cur.closer_progress < 2'd2)
                            st.closer_progress = cur.closer_progress + 2'd1;
                    end
                    else
                    begin
                        if (data_byte == 8'h3E && cur.closer_progress == 2'd2)
                            st.phase = PH_SEEK;
                        st.closer_progress = 2'd0;
                    end
                end
                default:
                begin
                    if (data_byte == 8'h3C)
                    begin
                        st.phase = PH_NAME;
                        st.name_match_mask = {NUM_CAND{1'b1}};
                        st.name_position = 3'd0;
                    end
                end
            endcase
        end

        if (end_of_doc)
        begin
            if (!st.decided)
                rs = '{emit: 1'b1, feed_kind: KIND_UNKNOWN, cause: CAUSE_ENDED};
            st = SCAN_RESET;
        end

        nxt = st;
        res = rs;
    end

endmodule

`default_nettype wire

[hw/rtl/feed_root_tag_sniffer_top.sv]
// Top level of the feed root tag sniffer: input register, scan state and result register.
//
// Channel   Direction  Handshake            Beat contents
// input     in         in_valid / in_stall  data_byte, end_of_doc
// result    out        out_valid / out_stall feed_kind, cause
//
// One byte is accepted every cycle unless the input channel is stalled; the byte that decides a result
// passes through the input register, the scan logic and the result register before the result appears.
// Reset clears the scan state and both valid flags; there is no clearing pass.
// A stalled result holds the byte in the input register, which then stalls the input channel.
`default_nettype none

module feed_root_tag_sniffer_top (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] data_byte,
    input  logic       end_of_doc,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [1:0] feed_kind,
    output logic [1:0] cause
);
    import frts_pkg::*;

    logic         in_valid_reg;
    logic [7:0]   byte_reg;
    logic         eod_reg;
    scan_state_t  st_reg;
    scan_state_t  st_next;
    scan_result_t res_next;
    logic         out_valid_reg;
    logic [1:0]   kind_reg;
    logic [1:0]   cause_reg;
    logic         advance;
    logic         accept;
    logic         fire;

    frts_step u_step (
        .cur        (st_reg),
        .data_byte  (byte_reg),
        .end_of_doc (eod_reg),
        .nxt        (st_next),
        .res        (res_next)
    );

    assign advance  = !out_valid_reg || !out_stall;
    assign fire     = in_valid_reg && advance;
    assign in_stall = in_valid_reg && !advance;
    assign accept   = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            st_reg        <= SCAN_RESET;
        end
        else
        begin
            if (accept)
                in_valid_reg <= 1'b1;
            else if (advance)
                in_valid_reg <= 1'b0;

            if (fire)
                st_reg <= st_next;

            if (fire && res_next.emit)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            byte_reg <= data_byte;
            eod_reg  <= end_of_doc;
        end
        if (fire && res_next.emit)
        begin
            kind_reg  <= res_next.feed_kind;
            cause_reg <= res_next.cause;
        end
    end

    assign out_valid = out_valid_reg;
    assign feed_kind = kind_reg;
    assign cause     = cause_reg;

    a_kind_needs_recognised: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && kind_reg != KIND_UNKNOWN |-> cause_reg == CAUSE_RECOGNISED)
        else $error("feed kind given without a recognised tag");

    a_cause_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> cause_reg <= CAUSE_ENDED)
        else $error("undefined cause code");

    a_end_resets: assert property (@(posedge clk) disable iff (!rst_n)
        fire && eod_reg |=> st_reg.phase == PH_SEEK && !st_reg.decided)
        else $error("scan state not reset after the last byte");

    a_silent_after_decision: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && st_reg.decided |-> !res_next.emit)
        else $error("second result for one document");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_stall |-> !fire)
        else $error("stalled result overwritten");

endmodule

`default_nettype wire

[test/tb_top.sv]
// Self-checking testbench for the feed root tag sniffer top level.
`timescale 1ns / 1ps

module tb_top;

    import frts_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int MAX_SHOWN   = 10;

    typedef logic [7:0] byte_q_t[$];

    typedef struct packed {
        logic [1:0] kind;
        logic [1:0] cause;
    } verdict_t;

    logic       clk;
    logic       rst_n      = 1'b0;
    logic       in_valid   = 1'b0;
    logic [7:0] data_byte  = 8'h00;
    logic       end_of_doc = 1'b0;
    logic       out_stall  = 1'b0;
    logic       in_stall;
    logic       out_valid;
    logic [1:0] feed_kind;
    logic [1:0] cause;

    string      tag_name [NUM_CAND];
    verdict_t   pending_verdicts[$];
    int         err_count   = 0;
    int         cycle_count = 0;
    int         bytes_sent  = 0;
    int         idle_pct    = 0;
    int         stall_pct   = 0;

    phase_t              scan_phase;
    logic [NUM_CAND-1:0] live_mask;
    logic [2:0]          name_pos;
    logic [1:0]          closer_cnt;
    logic                doc_decided;

    feed_root_tag_sniffer_top u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .data_byte  (data_byte),
        .end_of_doc (end_of_doc),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .feed_kind  (feed_kind),
        .cause      (cause)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("tb_top: done, errors");
        $finish;
    end

    task automatic reset_scan();
        scan_phase  = PH_SEEK;
        live_mask   = '1;
        name_pos    = 3'd0;
        closer_cnt  = 2'd0;
        doc_decided = 1'b0;
    endtask

    task automatic classify_byte(input logic [7:0] b, input logic eod);
        logic [7:0]          lb;
        logic [NUM_CAND-1:0] nxt;
        logic [1:0]          kind;
        int                  i;
        int                  done;
        lb = (b >= "A" && b <= "Z") ? b + 8'd32 : b;
        if (!doc_decided)
        begin
            case (scan_phase)
                PH_NAME:
                begin
                    nxt  = '0;
                    done = -1;
                    for (i = 0; i < NUM_CAND; i++)
                        if (live_mask[i] && name_pos < tag_name[i].len()
                            && tag_name[i][name_pos] == lb)
                            nxt[i] = 1'b1;
                    live_mask = nxt;
                    if (nxt == '0)
                    begin
                        pending_verdicts.push_back(verdict_t'{KIND_UNKNOWN, CAUSE_MISMATCH});
                        doc_decided = 1'b1;
                    end
                    else
                    begin
                        for (i = 0; i < NUM_CAND; i++)
                            if (nxt[i] && tag_name[i].len() == name_pos + 1)
                                done = i;
                        if (done < 0)
                            name_pos = name_pos + 3'd1;
                        else if (done == CAND_XML || done == CAND_COMMENT)
                        begin
                            scan_phase = (done == CAND_XML) ? PH_DECL : PH_COMMENT;
                            closer_cnt = 2'd0;
                        end
                        else
                        begin
                            live_mask       = '0;
                            live_mask[done] = 1'b1;
                            scan_phase      = PH_DELIM;
                        end
                    end
                end
                PH_DELIM:
                begin
                    kind = KIND_UNKNOWN;
                    if (live_mask[CAND_RSS])
                        kind = KIND_RSS2;
                    else if (live_mask[CAND_FEED])
                        kind = KIND_ATOM;
                    else if (live_mask[CAND_RDF])
                        kind = KIND_RSS1;
                    if ((b == 8'h20 || (b >= 8'h09 && b <= 8'h0D)) && kind != KIND_UNKNOWN)
                        pending_verdicts.push_back(verdict_t'{kind, CAUSE_RECOGNISED});
                    else
                        pending_verdicts.push_back(verdict_t'{KIND_UNKNOWN, CAUSE_MISMATCH});
                    doc_decided = 1'b1;
                end
                PH_DECL:
                begin
                    if (closer_cnt == 2'd1 && b == ">")
                    begin
                        scan_phase = PH_SEEK;
                        closer_cnt = 2'd0;
                    end
                    else
                        closer_cnt = (b == "?") ? 2'd1 : 2'd0;
                end
                PH_COMMENT:
                begin
                    if (b == "-")
                    begin
                        if (closer_cnt < 2'd2)
                            closer_cnt = closer_cnt + 2'd1;
                    end
                    else
                    begin
                        if (b == ">" && closer_cnt == 2'd2)
                            scan_phase = PH_SEEK;
                        closer_cnt = 2'd0;
                    end
                end
                default:
                begin
                    if (b == "<")
                    begin
                        scan_phase = PH_NAME;
                        live_mask  = '1;
                        name_pos   = 3'd0;
                    end
                end
            endcase
        end
        if (eod)
        begin
            if (!doc_decided)
                pending_verdicts.push_back(verdict_t'{KIND_UNKNOWN, CAUSE_ENDED});
            reset_scan();
        end
    endtask

    task automatic send_byte(input logic [7:0] b, input logic eod);
        while ($urandom_range(0, 99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        data_byte  <= b;
        end_of_doc <= eod;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        bytes_sent++;
        classify_byte(b, eod);
    endtask

    task automatic send_doc(input byte_q_t d);
        int i;
        for (i = 0; i < d.size(); i++)
            send_byte(d[i], i == d.size() - 1);
    endtask

    function automatic byte_q_t text_bytes(input string s);
        byte_q_t d;
        int      i;
        for (i = 0; i < s.len(); i++)
            d.push_back(s[i]);
        return d;
    endfunction

    function automatic logic [7:0] random_case(input logic [7:0] b);
        if (b >= "a" && b <= "z" && $urandom_range(0, 1) == 1)
            return b - 8'd32;
        return b;
    endfunction

    function automatic void append_name(ref byte_q_t d, input int cand, input int count);
        int i;
        for (i = 0; i < count; i++)
            d.push_back(random_case(tag_name[cand][i]));
    endfunction

    function automatic byte_q_t random_doc();
        byte_q_t    d;
        logic [7:0] b;
        logic [7:0] spaces [6];
        int         n;
        int         i;
        int         pick;
        int         sel;
        spaces = '{8'h20, 8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D};
        if ($urandom_range(0, 6) == 0)
        begin
            n = $urandom_range(1, 12);
            for (i = 0; i < n; i++)
            begin
                pick = $urandom_range(0, NUM_CAND - 1);
                case ($urandom_range(0, 3))
                    0:       b = "<";
                    1:       b = 8'($urandom_range(0, 255));
                    default: b = random_case(tag_name[pick][$urandom_range(0,
                                             tag_name[pick].len() - 1)]);
                endcase
                d.push_back(b);
            end
            return d;
        end
        n = $urandom_range(0, 3);
        for (i = 0; i < n; i++)
        begin
            b = 8'($urandom_range(0, 255));
            d.push_back(b == "<" ? "." : b);
        end
        if ($urandom_range(0, 2) == 0)
        begin
            pick = ($urandom_range(0, 1) == 0) ? CAND_XML : CAND_COMMENT;
            d.push_back("<");
            append_name(d, pick, tag_name[pick].len());
            n = $urandom_range(0, 4);
            for (i = 0; i < n; i++)
            begin
                case ($urandom_range(0, 3))
                    0:       d.push_back("?");
                    1:       d.push_back("-");
                    2:       d.push_back(">");
                    default: d.push_back("x");
                endcase
            end
            if (pick == CAND_XML)
                d = {d, text_bytes("?>")};
            else
                d = {d, text_bytes("-->")};
        end
        d.push_back("<");
        sel = $urandom_range(0, 7);
        if (sel < 6)
            append_name(d, sel % 3, tag_name[sel % 3].len());
        else if (sel == 6)
        begin
            pick = $urandom_range(0, NUM_CAND - 1);
            append_name(d, pick, $urandom_range(1, tag_name[pick].len() - 1));
            d.push_back(8'($urandom_range(0, 255)));
        end
        else
        begin
            n = $urandom_range(1, 4);
            for (i = 0; i < n; i++)
                d.push_back(8'($urandom_range(0, 255)));
        end
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: d.push_back(spaces[$urandom_range(0, 5)]);
            6:                d.push_back(8'h08);
            7:                d.push_back(8'h0E);
            8:                d.push_back(">");
            default:          d.push_back(8'($urandom_range(0, 255)));
        endcase
        n = $urandom_range(0, 3);
        for (i = 0; i < n; i++)
            d.push_back(8'($urandom_range(0, 255)));
        if ($urandom_range(0, 6) == 0)
        begin
            n = $urandom_range(1, d.size());
            d = d[0:n-1];
        end
        return d;
    endfunction

    task automatic note_error(input string msg);
        err_count++;
        if (err_count <= MAX_SHOWN)
            $display("%s", msg);
    endtask

    always @(posedge clk)
    begin
        verdict_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_verdicts.size() == 0)
                note_error($sformatf("%0t: unexpected result kind=%0d cause=%0d",
                                     $time, feed_kind, cause));
            else
            begin
                want = pending_verdicts.pop_front();
                if (want.kind !== feed_kind || want.cause !== cause)
                    note_error($sformatf("%0t: kind exp %0d got %0d, cause exp %0d got %0d",
                                         $time, want.kind, feed_kind, want.cause, cause));
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else
            out_stall <= ($urandom_range(0, 99) < stall_pct);
    end

    task automatic test_directed_cases();
        byte_q_t d;
        idle_pct  = 0;
        stall_pct = 0;
        send_doc(text_bytes("<rss "));
        send_doc(text_bytes("<FEED\t"));
        send_doc(text_bytes("<rdf:RDF\n"));
        send_doc(text_bytes("<rssx"));
        send_doc(text_bytes("<rss"));
        send_doc(text_bytes("<?xml?><feed\f"));
        send_doc(text_bytes("<!---->< "));
        send_doc(text_bytes("<rsS\rabc"));
        d = text_bytes("a");
        d.push_back(8'h00);
        d.push_back(8'hFF);
        send_doc(d);
        d = text_bytes("<");
        d.push_back(8'hC1);
        send_doc(d);
        send_doc(text_bytes("<!--x"));
    endtask

    task automatic test_random_docs(input int idle, input int stall, input int budget);
        int start;
        idle_pct  = idle;
        stall_pct = stall;
        start     = bytes_sent;
        while (bytes_sent - start < budget)
            send_doc(random_doc());
    endtask

    initial
    begin
        tag_name[CAND_RSS]     = "rss";
        tag_name[CAND_FEED]    = "feed";
        tag_name[CAND_RDF]     = "rdf:rdf";
        tag_name[CAND_XML]     = "?xml";
        tag_name[CAND_COMMENT] = "!--";
        reset_scan();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_cases();
        test_random_docs(0, 0, 310);
        test_random_docs(57, 0, 310);
        test_random_docs(0, 57, 310);
        test_random_docs(14, 14, 310);

        in_valid  <= 1'b0;
        stall_pct = 0;
        while (pending_verdicts.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (err_count == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end

endmodule
